// ----- sv/psse_pkg.sv -----
// Shared types, constants and helper functions for the preamp setting step encoder.
`default_nettype none

package psse_pkg;

    localparam int unsigned OP_W      = 4;
    localparam int unsigned LEVEL_W   = 6;
    localparam int unsigned ATTEN_W   = 5;
    localparam int unsigned GAIN_W    = 2;
    localparam int unsigned TONE_W    = 4;
    localparam int unsigned PATTERN_W = 3;
    localparam int unsigned MASK_W    = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NUM_ATTEN = 4;

    localparam logic [LEVEL_W-1:0]   VOLUME_MAX    = 6'd63;
    localparam logic [ATTEN_W-1:0]   ATTEN_MAX     = 5'd31;
    localparam logic [GAIN_W-1:0]    GAIN_MAX      = 2'd3;
    localparam logic [TONE_W-1:0]    TONE_MAX      = 4'd14;
    localparam logic [TONE_W-1:0]    TONE_FLAT     = 4'd7;
    localparam logic [PATTERN_W-1:0] PATTERN_LAST  = 3'd5;
    localparam logic [BYTE_W-1:0]    ADDRESS_RESET = 8'd136;

    // Command subaddress prefixes
    localparam logic [BYTE_W-1:0] SUB_VOLUME = 8'h00;
    localparam logic [BYTE_W-1:0] SUB_GAIN   = 8'h40;
    localparam logic [BYTE_W-1:0] SUB_BASS   = 8'h60;
    localparam logic [BYTE_W-1:0] SUB_TREBLE = 8'h70;
    localparam logic [BYTE_W-1:0] SUB_ATTEN  = 8'h80;

    typedef enum logic [OP_W-1:0] {
        OP_VOLUME   = 4'd0,
        OP_ATTEN_FL = 4'd1,
        OP_ATTEN_FR = 4'd2,
        OP_ATTEN_RL = 4'd3,
        OP_ATTEN_RR = 4'd4,
        OP_GAIN     = 4'd5,
        OP_BASS     = 4'd6,
        OP_TREBLE   = 4'd7,
        OP_SELECT   = 4'd8
    } op_t;

    typedef struct packed {
        logic                sent;
        logic [BYTE_W-1:0]   address_byte;
        logic [BYTE_W-1:0]   command_byte;
        logic [MASK_W-1:0]   speaker_mask;
        logic                unmute;
    } result_t;

    // Saturating step on a zero-extended value; returns {changed, new value}.
    function automatic logic [LEVEL_W:0] sat_step(input logic [LEVEL_W-1:0] v,
                                                  input logic up,
                                                  input logic [LEVEL_W-1:0] lim);
        logic [LEVEL_W:0] r;
        r = {1'b0, v};
        if (up)
        begin
            if (v < lim)
                r = {1'b1, v + 6'd1};
        end
        else
        begin
            if (v != '0)
                r = {1'b1, v - 6'd1};
        end
        return r;
    endfunction

    // Steps 0..7 pass through, 8..14 fold to 22 - step.
    function automatic logic [TONE_W-1:0] tone_code(input logic [TONE_W-1:0] step);
        logic [TONE_W:0] folded;
        folded = 5'd22 - {1'b0, step};
        return step[TONE_W-1] ? folded[TONE_W-1:0] : step;
    endfunction

    function automatic logic [MASK_W-1:0] pattern_mask(input logic [PATTERN_W-1:0] p);
        logic [MASK_W-1:0] m;
        unique case (p)
            3'd0:    m = 4'h1;
            3'd1:    m = 4'h2;
            3'd2:    m = 4'h4;
            3'd3:    m = 4'h8;
            3'd4:    m = 4'h3;
            3'd5:    m = 4'hC;
            default: m = 4'h0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/psse_step_unit.sv -----
// Shadow setting registers and the combinational step/encode logic.
`default_nettype none

module psse_step_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step_en,
    input  wire logic [psse_pkg::OP_W-1:0]     op,
    input  wire logic                          step_down,
    input  wire logic [psse_pkg::BYTE_W-1:0]   device_address,
    output psse_pkg::result_t                  result
);

    logic [psse_pkg::LEVEL_W-1:0]   volume_reg, volume_next;
    logic [psse_pkg::ATTEN_W-1:0]   atten_reg [psse_pkg::NUM_ATTEN];
    logic [psse_pkg::ATTEN_W-1:0]   atten_next [psse_pkg::NUM_ATTEN];
    logic [psse_pkg::GAIN_W-1:0]    gain_reg, gain_next;
    logic [psse_pkg::TONE_W-1:0]    bass_reg, bass_next;
    logic [psse_pkg::TONE_W-1:0]    treble_reg, treble_next;
    logic [psse_pkg::PATTERN_W-1:0] pattern_reg, pattern_next;

    psse_pkg::op_t                  op_code;
    logic [1:0]                     atten_idx;
    logic [psse_pkg::LEVEL_W:0]     vol_s, atten_s, gain_s, bass_s, treble_s;
    logic [psse_pkg::OP_W-1:0]      atten_sel;

    assign op_code   = psse_pkg::op_t'(op);
    assign atten_sel = op - 4'd1;
    assign atten_idx = atten_sel[1:0];

    // Volume, attenuators and gain count down on "plus"; tone counts up.
    assign vol_s    = psse_pkg::sat_step(volume_reg, step_down, psse_pkg::VOLUME_MAX);
    assign atten_s  = psse_pkg::sat_step({1'b0, atten_reg[atten_idx]}, step_down,
                                         {1'b0, psse_pkg::ATTEN_MAX});
    assign gain_s   = psse_pkg::sat_step({4'd0, gain_reg}, step_down,
                                         {4'd0, psse_pkg::GAIN_MAX});
    assign bass_s   = psse_pkg::sat_step({2'd0, bass_reg}, !step_down,
                                         {2'd0, psse_pkg::TONE_MAX});
    assign treble_s = psse_pkg::sat_step({2'd0, treble_reg}, !step_down,
                                         {2'd0, psse_pkg::TONE_MAX});

    always_comb
    begin
        logic                          changed;
        logic [psse_pkg::BYTE_W-1:0]   cmd;
        changed      = 1'b0;
        cmd          = '0;
        volume_next  = volume_reg;
        atten_next   = atten_reg;
        gain_next    = gain_reg;
        bass_next    = bass_reg;
        treble_next  = treble_reg;
        pattern_next = pattern_reg;
        unique case (op_code)
            psse_pkg::OP_VOLUME:
            begin
                changed     = vol_s[psse_pkg::LEVEL_W];
                volume_next = vol_s[psse_pkg::LEVEL_W-1:0];
                cmd         = psse_pkg::SUB_VOLUME | {2'd0, volume_next};
            end
            psse_pkg::OP_ATTEN_FL, psse_pkg::OP_ATTEN_FR,
            psse_pkg::OP_ATTEN_RL, psse_pkg::OP_ATTEN_RR:
            begin
                changed               = atten_s[psse_pkg::LEVEL_W];
                atten_next[atten_idx] = atten_s[psse_pkg::ATTEN_W-1:0];
                cmd = psse_pkg::SUB_ATTEN | {1'b0, atten_idx, 5'd0}
                      | {3'd0, atten_s[psse_pkg::ATTEN_W-1:0]};
            end
            psse_pkg::OP_GAIN:
            begin
                changed   = gain_s[psse_pkg::LEVEL_W];
                gain_next = gain_s[psse_pkg::GAIN_W-1:0];
                cmd       = psse_pkg::SUB_GAIN | {3'd0, gain_next, 3'd0};
            end
            psse_pkg::OP_BASS:
            begin
                changed   = bass_s[psse_pkg::LEVEL_W];
                bass_next = bass_s[psse_pkg::TONE_W-1:0];
                cmd       = psse_pkg::SUB_BASS | {4'd0, psse_pkg::tone_code(bass_next)};
            end
            psse_pkg::OP_TREBLE:
            begin
                changed     = treble_s[psse_pkg::LEVEL_W];
                treble_next = treble_s[psse_pkg::TONE_W-1:0];
                cmd = psse_pkg::SUB_TREBLE | {4'd0, psse_pkg::tone_code(treble_next)};
            end
            psse_pkg::OP_SELECT:
            begin
                if (pattern_reg < psse_pkg::PATTERN_LAST)
                    pattern_next = pattern_reg + 3'd1;
                else
                    pattern_next = '0;
            end
            default:
            begin
                changed = 1'b0;
            end
        endcase

        result.sent         = changed;
        result.address_byte = changed ? device_address : '0;
        result.command_byte = changed ? cmd : '0;
        result.speaker_mask = psse_pkg::pattern_mask(pattern_next);
        result.unmute       = changed && (op_code == psse_pkg::OP_VOLUME);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg  <= psse_pkg::VOLUME_MAX;
            for (int i = 0; i < psse_pkg::NUM_ATTEN; i++)
                atten_reg[i] <= '0;
            gain_reg    <= '0;
            bass_reg    <= psse_pkg::TONE_FLAT;
            treble_reg  <= psse_pkg::TONE_FLAT;
            pattern_reg <= '0;
        end
        else if (step_en)
        begin
            volume_reg  <= volume_next;
            atten_reg   <= atten_next;
            gain_reg    <= gain_next;
            bass_reg    <= bass_next;
            treble_reg  <= treble_next;
            pattern_reg <= pattern_next;
        end
    end

    a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
        bass_reg <= psse_pkg::TONE_MAX && treble_reg <= psse_pkg::TONE_MAX)
        else $error("tone step out of range");

    a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_reg <= psse_pkg::PATTERN_LAST)
        else $error("speaker pattern out of range");

    a_unmute_sent: assert property (@(posedge clk) disable iff (!rst_n)
        result.unmute |-> result.sent)
        else $error("unmute without a command");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(volume_reg) && $stable(pattern_reg) && $stable(gain_reg))
        else $error("settings changed with no transaction");

endmodule

`default_nettype wire

// ----- sv/preamp_setting_step_encoder.sv -----
// Top level: stream ports, input and result registers around the step unit.
//
// Each control event (a setting selector and a direction) steps one saturating shadow
// setting, or cycles the wrapping speaker pattern, and yields exactly one result
// transaction: sent=1 with the device address and command byte when the value changed,
// zeros otherwise, plus the current speaker enable mask and an unmute pulse on volume
// change. The block takes one event per clock unless the master side stalls; a result
// passes the input register, then the result register, and the settings update in the
// same cycle the event leaves the input register, so each event sees the effect of the
// one before it. The device address resets to 136 and is written through cfg_we/cfg_wdata;
// the user must write it only while no event is in flight; the block does not enforce it.
`default_nettype none

module preamp_setting_step_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,      // device_address

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] step_down, [7:1] zero
    input  wire logic [3:0]  s_axis_tuser,   // [3:0] op

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] address_byte, [15:8] command_byte,
                                             // [19:16] speaker_mask, [20] unmute, rest zero
    output logic             m_axis_tuser    // [0] sent
);

    logic                           in_valid_reg;
    logic [psse_pkg::OP_W-1:0]      in_op_reg;
    logic                           in_down_reg;
    logic                           out_valid_reg;
    psse_pkg::result_t              out_reg;
    psse_pkg::result_t              step_result;
    logic [psse_pkg::BYTE_W-1:0]    address_reg;
    logic                           advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    psse_step_unit u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (advance),
        .op             (in_op_reg),
        .step_down      (in_down_reg),
        .device_address (address_reg),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg   <= psse_pkg::ADDRESS_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                address_reg <= cfg_wdata;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= s_axis_tuser;
            in_down_reg <= s_axis_tdata[0];
        end
        if (advance)
            out_reg <= step_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.sent;
    assign m_axis_tdata  = {3'd0, out_reg.unmute, out_reg.speaker_mask,
                            out_reg.command_byte, out_reg.address_byte};

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !advance)
        else $error("result register overwritten while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("stepped event produced no result");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0 && !m_axis_tdata[20])
        else $error("bytes present without a command");

endmodule

`default_nettype wire
